/* sv/csh_pkg.sv */
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types, constants and saturating arithmetic for the class set
// histogram: payload structs, row word layout and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csh_pkg;

  // Number of classes tracked; sets the number of rows and lanes per row.
  localparam int NUM_CLASSES  = 16;

  // Fixed payload field widths.
  localparam int MASK_W       = 16;
  localparam int FREQ_W       = 32;
  localparam int QROW_W       = 5;
  localparam int QCLASS_W     = 4;
  localparam int LEAF_W       = 32;
  localparam int VISIT_W      = 48;

  // Mask bits that can name a tracked class.
  localparam int USED_CLASSES = (NUM_CLASSES < MASK_W) ? NUM_CLASSES : MASK_W;
  // Width of a set-bit count over the usable mask bits.
  localparam int CNT_W        = $clog2(USED_CLASSES + 1);
  // Row address and lane index width.
  localparam int IDX_W        = $clog2(NUM_CLASSES);

  typedef enum logic [0:0] {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } csh_cmd_e;

  typedef struct packed {
    csh_cmd_e              cmd;
    logic [MASK_W-1:0]     class_mask;
    logic [FREQ_W-1:0]     visit_freq;
    logic [QROW_W-1:0]     query_row;
    logic [QCLASS_W-1:0]   query_class;
  } csh_in_t;

  typedef struct packed {
    logic [LEAF_W-1:0]     leaf_count;
    logic [VISIT_W-1:0]    visit_sum;
    logic [LEAF_W-1:0]     total_leaves;
    logic [VISIT_W-1:0]    total_visits;
  } csh_out_t;

  // One histogram cell: both counters side by side.
  typedef struct packed {
    logic [LEAF_W-1:0]     leaves;
    logic [VISIT_W-1:0]    visits;
  } csh_cell_t;

  // One memory word: a whole row, one cell per class lane.
  typedef csh_cell_t [NUM_CLASSES-1:0] csh_row_t;

  // Memory port control.
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } csh_ram_req_t;

  // Saturating increment of a leaf counter.
  function automatic logic [LEAF_W-1:0] sat_inc_leaf(logic [LEAF_W-1:0] a);
    logic [LEAF_W:0] s;
    s = {1'b0, a} + {{LEAF_W{1'b0}}, 1'b1};
    return s[LEAF_W] ? {LEAF_W{1'b1}} : s[LEAF_W-1:0];
  endfunction

  // Saturating add of a visit frequency into a visit counter.
  function automatic logic [VISIT_W-1:0] sat_add_visit(logic [VISIT_W-1:0] a,
                                                       logic [FREQ_W-1:0]  b);
    logic [VISIT_W:0] s;
    s = {1'b0, a} + {{(VISIT_W - FREQ_W + 1){1'b0}}, b};
    return s[VISIT_W] ? {VISIT_W{1'b1}} : s[VISIT_W-1:0];
  endfunction

  // Keep only the mask bits of tracked classes, one bit per lane.
  function automatic logic [NUM_CLASSES-1:0] lane_mask(logic [MASK_W-1:0] m);
    logic [NUM_CLASSES-1:0] r;
    r = '0;
    for (int i = 0; i < USED_CLASSES; i++) begin
      r[i] = m[i];
    end
    return r;
  endfunction

  // Number of tracked classes set in the mask.
  function automatic logic [CNT_W-1:0] class_count(logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < USED_CLASSES; i++) begin
      cnt = cnt + CNT_W'(m[i]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

/* sv/csh_row_ram.sv */
// ----------------------------------------------------------------------------
// csh_row_ram
// Row-wide histogram memory: one word per row, registered read data, and a
// valid bit per row so that rows never written read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module csh_row_ram (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  csh_pkg::csh_ram_req_t req_i,
  input  csh_pkg::csh_row_t     wdata_i,
  output csh_pkg::csh_row_t     rdata_o
);

  csh_pkg::csh_row_t                  mem [csh_pkg::NUM_CLASSES];
  csh_pkg::csh_row_t                  rdata_q;
  logic [csh_pkg::NUM_CLASSES-1:0]    row_valid_q;
  logic                               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // Mark rows on first write; capture the row's mark with each read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= row_valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* sv/csh_lane_upd.sv */
// ----------------------------------------------------------------------------
// csh_lane_upd
// Lane-wise update of one histogram row: each lane whose class is set gets
// a saturating leaf increment and a saturating add of the visit frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module csh_lane_upd (
  input  csh_pkg::csh_row_t                 row_i,
  input  wire [csh_pkg::NUM_CLASSES-1:0]    lanes_i,
  input  wire [csh_pkg::FREQ_W-1:0]         freq_i,
  output csh_pkg::csh_row_t                 row_o
);

  always_comb begin
    for (int i = 0; i < csh_pkg::NUM_CLASSES; i++) begin
      if (lanes_i[i]) begin
        row_o[i].leaves = csh_pkg::sat_inc_leaf(row_i[i].leaves);
        row_o[i].visits = csh_pkg::sat_add_visit(row_i[i].visits, freq_i);
      end else begin
        row_o[i] = row_i[i];
      end
    end
  end

endmodule

`default_nettype wire

/* sv/class_set_histogram.sv */
// ----------------------------------------------------------------------------
// class_set_histogram
// Two-dimensional histogram of leaf records over (number of possible
// classes, class index), with saturating leaf and visit counters and totals.
// ----------------------------------------------------------------------------
// Flow: a new transfer is taken only once the last item completes, set by the
//   read-modify-write of a row word through the single-port-read histogram memory.
// Read path: the memory registers the row, then BUSY loads the result; the
//   command waits in BUSY while the output register is full and not taken.
// Reset: asynchronous; clears control, totals and the per-row valid bits at
//   once, so every cell reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module class_set_histogram (
  input  wire                clk_i,
  input  wire                rst_ni,

  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  csh_pkg::csh_in_t   in_i,

  output logic               out_valid_o,
  input  wire                out_ready_i,
  output csh_pkg::csh_out_t  out_o
);

  // Sequencer: IDLE takes a transfer and launches the row read; BUSY holds
  // the row data, writes the updated row back or loads the result register.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } csh_state_e;

  csh_state_e state_q, state_d;

  // Held item fields, captured at the input transfer.
  csh_pkg::csh_cmd_e                  cmd_q;
  logic [csh_pkg::NUM_CLASSES-1:0]    lanes_q;
  logic [csh_pkg::FREQ_W-1:0]         freq_q;
  logic [csh_pkg::IDX_W-1:0]          row_q;
  logic [csh_pkg::IDX_W-1:0]          lane_q;
  logic                               has_row_q;
  logic                               query_ok_q;

  // Running totals.
  logic [csh_pkg::LEAF_W-1:0]         leaves_total_q, leaves_total_d;
  logic [csh_pkg::VISIT_W-1:0]        visits_total_q, visits_total_d;

  // Result register.
  logic                               out_valid_q, out_valid_d;
  csh_pkg::csh_out_t                  out_q, out_d;

  logic                               in_xfer;
  logic                               done;
  logic [csh_pkg::CNT_W-1:0]          in_count;
  logic [csh_pkg::IDX_W-1:0]          acc_row;
  logic [csh_pkg::IDX_W-1:0]          query_addr;
  logic                               query_ok;

  csh_pkg::csh_ram_req_t              ram_req;
  csh_pkg::csh_row_t                  ram_rdata;
  csh_pkg::csh_row_t                  upd_row;

  // --------------------------------------------------------------------------
  // Input decode: the number of set classes picks the row of an accumulate;
  // a read addresses row query_row - 1; an out-of-range row or class reads zero.
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_count   = csh_pkg::class_count(in_i.class_mask);
  assign acc_row    = csh_pkg::IDX_W'(in_count - csh_pkg::CNT_W'(1));
  assign query_addr = csh_pkg::IDX_W'(in_i.query_row - csh_pkg::QROW_W'(1));
  assign query_ok   = (in_i.query_row != '0) &&
                      (int'(in_i.query_row) <= csh_pkg::NUM_CLASSES) &&
                      (int'(in_i.query_class) < csh_pkg::NUM_CLASSES);

  // --------------------------------------------------------------------------
  // Completion: an accumulate always finishes in BUSY; a read finishes once
  // the result register is free or being emptied in the same cycle.
  // --------------------------------------------------------------------------
  assign done = (state_q == ST_BUSY) &&
                ((cmd_q == csh_pkg::CMD_ACCUM) || !out_valid_q || out_ready_i);

  // Memory control: read the row on the transfer, write it back on completion.
  // Reads and writes never share a cycle, so no forwarding is needed.
  always_comb begin
    ram_req.re    = in_xfer;
    ram_req.raddr = (in_i.cmd == csh_pkg::CMD_READ) ? query_addr : acc_row;
    ram_req.we    = done && (cmd_q == csh_pkg::CMD_ACCUM) && has_row_q;
    ram_req.waddr = row_q;
  end

  csh_row_ram u_row_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .wdata_i (upd_row),
    .rdata_o (ram_rdata)
  );

  csh_lane_upd u_lane_upd (
    .row_i   (ram_rdata),
    .lanes_i (lanes_q),
    .freq_i  (freq_q),
    .row_o   (upd_row)
  );

  // --------------------------------------------------------------------------
  // Next state, totals and result register.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    leaves_total_d = leaves_total_q;
    visits_total_d = visits_total_q;
    out_valid_d    = out_valid_q;
    out_d          = out_q;

    // Drop the result once the downstream side takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_d = ST_IDLE;
          if (cmd_q == csh_pkg::CMD_ACCUM) begin
            // Every leaf counts toward the totals, even with no classes set.
            leaves_total_d = csh_pkg::sat_inc_leaf(leaves_total_q);
            visits_total_d = csh_pkg::sat_add_visit(visits_total_q, freq_q);
          end else begin
            out_valid_d        = 1'b1;
            out_d.leaf_count   = query_ok_q ? ram_rdata[lane_q].leaves : '0;
            out_d.visit_sum    = query_ok_q ? ram_rdata[lane_q].visits : '0;
            out_d.total_leaves = leaves_total_q;
            out_d.total_visits = visits_total_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      leaves_total_q <= '0;
      visits_total_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      leaves_total_q <= leaves_total_d;
      visits_total_q <= visits_total_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers: hold the item across the read-modify-write.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q      <= in_i.cmd;
      lanes_q    <= csh_pkg::lane_mask(in_i.class_mask);
      freq_q     <= in_i.visit_freq;
      row_q      <= acc_row;
      lane_q     <= csh_pkg::IDX_W'(in_i.query_class);
      has_row_q  <= (in_count != '0);
      query_ok_q <= query_ok;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* sv/csh_checker.sv */
// ----------------------------------------------------------------------------
// csh_checker
// Port-level checks for the class set histogram, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csh_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input csh_pkg::csh_in_t   in_i,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input csh_pkg::csh_out_t  out_o
);

  // Hold a result until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  // Each input transfer occupies the block for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  // A new result only follows a read transfer, through BUSY and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (in_i.cmd == csh_pkg::CMD_READ), 2))
    else $error("result without a read command");

  // A cell never counts more than the totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.leaf_count <= out_o.total_leaves) &&
                    (out_o.visit_sum <= out_o.total_visits))
    else $error("cell counter exceeds total");

endmodule

bind class_set_histogram csh_checker u_csh_checker (.*);

`default_nettype wire

/* tb/sv/csh_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_tb_pkg
// Mirror of the class set histogram: keeps its own copy of both cell tables
// and the two totals, predicts every read and checks the block's answers.
// ----------------------------------------------------------------------------

package csh_tb_pkg;

  import csh_pkg::*;

  localparam int CELL_COUNT = NUM_CLASSES * NUM_CLASSES;
  localparam int PRINT_CAP  = 100;

  class hist_mirror;

    bit [LEAF_W-1:0]  leaf_cells  [CELL_COUNT];
    bit [VISIT_W-1:0] visit_cells [CELL_COUNT];
    bit [LEAF_W-1:0]  leaves_sum;
    bit [VISIT_W-1:0] visits_sum;

    // Read answers still owed by the block, oldest first.
    csh_out_t         owed_reads [$];

    int errors;
    int records;
    int reads;
    int live_reads;
    int checked;

    function bit [LEAF_W-1:0] leaf_plus_one(bit [LEAF_W-1:0] a);
      return (a == '1) ? a : a + 1'b1;
    endfunction

    function bit [VISIT_W-1:0] visits_plus(bit [VISIT_W-1:0] a, bit [FREQ_W-1:0] f);
      bit [VISIT_W-1:0] top;
      top = '1;
      return (a > top - VISIT_W'(f)) ? top : a + VISIT_W'(f);
    endfunction

    // Update the tables for a leaf record, or queue the answer of a read.
    function void absorb(csh_in_t rec);
      int       ones;
      int       slot;
      csh_out_t view;
      if (rec.cmd == CMD_ACCUM) begin
        ones = 0;
        for (int i = 0; i < USED_CLASSES; i++) begin
          if (rec.class_mask[i]) ones++;
        end
        if (ones > 0) begin
          for (int i = 0; i < USED_CLASSES; i++) begin
            if (rec.class_mask[i]) begin
              slot = (ones - 1) * NUM_CLASSES + i;
              leaf_cells[slot]  = leaf_plus_one(leaf_cells[slot]);
              visit_cells[slot] = visits_plus(visit_cells[slot], rec.visit_freq);
            end
          end
        end
        leaves_sum = leaf_plus_one(leaves_sum);
        visits_sum = visits_plus(visits_sum, rec.visit_freq);
        records++;
      end else begin
        view.leaf_count = '0;
        view.visit_sum  = '0;
        if (rec.query_row >= 1 && rec.query_row <= NUM_CLASSES &&
            rec.query_class < NUM_CLASSES) begin
          slot = (int'(rec.query_row) - 1) * NUM_CLASSES + int'(rec.query_class);
          view.leaf_count = leaf_cells[slot];
          view.visit_sum  = visit_cells[slot];
        end
        view.total_leaves = leaves_sum;
        view.total_visits = visits_sum;
        owed_reads = {owed_reads, view};
        reads++;
        if (view.leaf_count != 0) live_reads++;
      end
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("[%0t] read %0d: %s", $time, checked, what);
      errors++;
    endtask

    task compare_read(csh_out_t got);
      csh_out_t want;
      if (owed_reads.size() == 0) begin
        report_mismatch("read result with no read command waiting");
        return;
      end
      want = owed_reads.pop_front();
      checked++;
      if (got.leaf_count !== want.leaf_count)
        report_mismatch($sformatf("leaf_count 0x%0h, want 0x%0h",
                                  got.leaf_count, want.leaf_count));
      if (got.visit_sum !== want.visit_sum)
        report_mismatch($sformatf("visit_sum 0x%0h, want 0x%0h",
                                  got.visit_sum, want.visit_sum));
      if (got.total_leaves !== want.total_leaves)
        report_mismatch($sformatf("total_leaves 0x%0h, want 0x%0h",
                                  got.total_leaves, want.total_leaves));
      if (got.total_visits !== want.total_visits)
        report_mismatch($sformatf("total_visits 0x%0h, want 0x%0h",
                                  got.total_visits, want.total_visits));
    endtask

    function int owed();
      return owed_reads.size();
    endfunction

  endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for class_set_histogram: a directed opening on the
// special cases, then random leaf records and cell reads under bursty input
// and a stalling receiver, every read answer checked against the mirror.
// ----------------------------------------------------------------------------

module testbench;

  import csh_pkg::*;
  import csh_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // Receiver stall modes, drawn at random for each stretch.
  localparam int STALL_NONE   = 0;
  localparam int STALL_HALF   = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_PERIOD = 3;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  csh_in_t  in_data   = '0;
  logic     out_ready = 1'b0;

  logic     in_ready_o;
  logic     out_valid_o;
  csh_out_t out_o;

  hist_mirror mirror;
  int         cycles     = 0;
  int         burst_left = 0;
  int         stall_mode = STALL_NONE;
  int         stall_tick = 0;

  class_set_histogram u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run hit the limit of %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: hold each stall mode for a stretch, then draw a mode again at random.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 96 == 95) stall_mode <= $urandom_range(STALL_NONE, STALL_PERIOD);
    case (stall_mode)
      STALL_NONE:   out_ready <= 1'b1;
      STALL_HALF:   out_ready <= 1'($urandom_range(0, 1));
      STALL_HEAVY:  out_ready <= ($urandom_range(0, 5) == 0);
      default:      out_ready <= (stall_tick % 7) > 2;
    endcase
  end

  // Watch both channels. Inputs change only through nonblocking assignments,
  // so the values read here are the ones present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) mirror.absorb(in_data);
      if (out_valid_o && out_ready) mirror.compare_read(out_o);
    end
  end

  function automatic csh_in_t leaf_record(logic [MASK_W-1:0] mask, logic [FREQ_W-1:0] freq);
    csh_in_t it;
    it.cmd         = CMD_ACCUM;
    it.class_mask  = mask;
    it.visit_freq  = freq;
    // The query fields carry noise; the block must ignore them here.
    it.query_row   = QROW_W'($urandom);
    it.query_class = QCLASS_W'($urandom);
    return it;
  endfunction

  function automatic csh_in_t cell_read(logic [QROW_W-1:0] row, logic [QCLASS_W-1:0] cls);
    csh_in_t it;
    it.cmd         = CMD_READ;
    it.class_mask  = MASK_W'($urandom);
    it.visit_freq  = $urandom;
    it.query_row   = row;
    it.query_class = cls;
    return it;
  endfunction

  // Masks spread over every popcount: sparse, dense, raw, a lone bit, or sparse plus a lone bit.
  function automatic logic [MASK_W-1:0] draw_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 4))
      0:       m = MASK_W'($urandom & $urandom & $urandom);
      1:       m = MASK_W'($urandom | $urandom | $urandom);
      2:       m = MASK_W'($urandom);
      3:       m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      default: m = MASK_W'($urandom & $urandom) |
                   (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
    endcase
    return m;
  endfunction

  function automatic logic [FREQ_W-1:0] draw_freq();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transfer; open a new burst, after a random gap, when the last
  // one is used up.
  task automatic send_item(csh_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    csh_in_t           opening [$];
    logic [MASK_W-1:0] recent [$];
    logic [MASK_W-1:0] m;
    int                cls;

    mirror = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty cells, a leaf with no classes, row zero, rows
    // past the last class, a full mask, lone end bits and saturating inputs.
    opening = {opening, cell_read(5'd1, 4'd0)};
    opening = {opening, leaf_record(16'h0000, 32'hFFFF_FFFF)};
    opening = {opening, cell_read(5'd0, 4'd0)};
    opening = {opening, leaf_record(16'hFFFF, 32'hFFFF_FFFF)};
    opening = {opening, cell_read(5'd16, 4'd15)};
    opening = {opening, cell_read(5'd16, 4'd0)};
    opening = {opening, leaf_record(16'h0001, 32'h0000_0000)};
    opening = {opening, leaf_record(16'h8000, 32'h0000_0001)};
    opening = {opening, cell_read(5'd1, 4'd0)};
    opening = {opening, cell_read(5'd1, 4'd15)};
    opening = {opening, cell_read(5'd17, 4'd0)};
    opening = {opening, cell_read(5'd31, 4'd15)};
    opening = {opening, leaf_record(16'hFFFF, 32'h1234_5678)};
    opening = {opening, cell_read(5'd16, 4'd7)};
    opening = {opening, leaf_record(16'h5555, 32'hAAAA_AAAA)};
    opening = {opening, leaf_record(16'hAAAA, 32'h5555_5555)};
    opening = {opening, cell_read(5'd8, 4'd0)};
    opening = {opening, cell_read(5'd8, 4'd1)};
    opening = {opening, leaf_record(16'h7FFF, 32'hFFFF_FFFF)};
    opening = {opening, cell_read(5'd15, 4'd14)};
    opening = {opening, cell_read(5'd15, 4'd15)};
    opening = {opening, cell_read(5'd0, 4'd15)};
    foreach (opening[i]) send_item(opening[i]);

    // Random part: mostly leaf records, reads aimed at cells that recent
    // leaves touched, plus reads anywhere in the query space.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        m = draw_mask();
        recent = {recent, m};
        if (recent.size() > 8) void'(recent.pop_front());
        send_item(leaf_record(m, draw_freq()));
      end else if (recent.size() > 0 && $urandom_range(0, 9) < 7) begin
        m   = recent[$urandom_range(0, recent.size() - 1)];
        cls = $urandom_range(0, MASK_W - 1);
        // Walk to the next set class so the read usually lands on a live cell.
        for (int k = 0; k < MASK_W && m != 0; k++) begin
          if (m[(cls + k) % MASK_W]) begin
            cls = (cls + k) % MASK_W;
            break;
          end
        end
        send_item(cell_read(QROW_W'($countones(m)), QCLASS_W'(cls)));
      end else begin
        send_item(cell_read(QROW_W'($urandom), QCLASS_W'($urandom)));
      end
    end
    in_valid <= 1'b0;

    // Drain the owed answers, then give stray results time to show up.
    while (mirror.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d leaf records and %0d cell reads; %0d reads found a nonzero cell.",
             mirror.records, mirror.reads, mirror.live_reads);
    $display("Checked %0d read answers, %0d mismatches.", mirror.checked, mirror.errors);
    if (mirror.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/csh_pkg.sv
sv/csh_row_ram.sv
sv/csh_lane_upd.sv
sv/class_set_histogram.sv
sv/csh_checker.sv
tb/sv/csh_tb_pkg.sv
tb/sv/testbench.sv
